// ----- hw/rtl/col_pkg.sv -----
package col_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths fixed by the interface
   localparam int IP_W     = 32;
   localparam int PORT_W   = 16;
   localparam int OWNER_W  = 32;
   localparam int CSTATE_W = 8;
   localparam int COUNT_W  = 7;
   localparam int CSR_W    = 16;
   localparam int REQ_W    = 136;
   localparam int RSP_W    = 48;

   // register reset values
   localparam logic [PORT_W-1:0] LOWEST_PORT_RESET = 16'd1024;
   localparam logic [CSR_W-1:0]  STATE_MASK_RESET  = 16'd1150;

   // register indexes
   localparam logic REG_LOWEST_PORT = 1'b0;
   localparam logic REG_STATE_MASK  = 1'b1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FILTERED = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   // one stored connection
   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [PORT_W-1:0]  peer_port;
      logic [IP_W-1:0]    peer_ip;
      logic [PORT_W-1:0]  own_port;
      logic [IP_W-1:0]    own_ip;
   } entry_type;

   // lookup key travelling down the chain
   typedef struct packed {
      logic              use1;
      logic              use2;
      logic [IP_W-1:0]   ip1;
      logic [PORT_W-1:0] port1;
      logic [IP_W-1:0]   ip2;
      logic [PORT_W-1:0] port2;
   } key_type;

   // partial lookup result travelling with the key
   typedef struct packed {
      logic               tok;
      logic               found;
      logic [OWNER_W-1:0] owner;
   } res_type;

   // table control broadcast to every cell
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [CNT_W-1:0] count;
   } ctl_type;

   // result word, lowest field last
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      status_type         status;
      logic               found;
      logic [OWNER_W-1:0] owner;
   } rsp_type;

endpackage

// ----- hw/rtl/connection_owner_lookup_top.sv -----
// Connection owner lookup table.
// Request words arrive on req_*: req_tuser carries the operation (clear,
// insert, lookup, code 3 is a no-op) and req_tdata the packed endpoints,
// owner id and connection state. Every request yields exactly one response
// word on rsp_* with owner, found flag, status and the entry count after the
// operation. Two registers are written through csr_we/csr_addr/csr_wdata:
// 0 lowest tracked port, 1 state mask. The user must write them only while
// no request is in flight; the block itself does not enforce this. Entries
// live in a row of TABLE_DEPTH cells, one entry per cell, stored in insertion
// order. A lookup key enters the first cell and moves one cell per cycle,
// carrying the first hit along; the result leaves the last cell. Clear,
// insert and no-op answer 1 cycle after acceptance and the next word can be
// taken at the edge where that answer leaves. A lookup result is captured
// from the last cell into a pending register in the scan state and loaded
// into the output register in the done state once the output is free;
// requests are handled one at a time. Reset empties the table (fill count
// zero) and loads the register defaults. A stalled response holds in the
// output register and req_tready stays low until it drains.
module connection_owner_lookup_top (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [1:0]                 req_tuser,  // operation
   // first_ip, first_port, second_ip, second_port, owner_id, conn_state
   input  logic [col_pkg::REQ_W-1:0]  req_tdata,
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // owner_out, found, status, entry_count_out, zero pad
   output logic [col_pkg::RSP_W-1:0]  rsp_tdata,
   // register write port
   input  logic                       csr_we,
   input  logic                       csr_addr,
   input  logic [col_pkg::CSR_W-1:0]  csr_wdata
);
   import col_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PORT_W-1:0]   lowest_port_ff;
   logic [CSR_W-1:0]    state_mask_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   res_type             pend_ff, pend_in;

   logic [IP_W-1:0]     first_ip;
   logic [PORT_W-1:0]   first_port;
   logic [IP_W-1:0]     second_ip;
   logic [PORT_W-1:0]   second_port;
   logic [OWNER_W-1:0]  owner_id;
   logic [CSTATE_W-1:0] conn_state;
   op_type              op;
   logic                req_accept;
   logic                filtered;
   logic                full;
   ctl_type             ctl;
   entry_type           wr_entry;

   key_type             key_chain [TABLE_DEPTH+1];
   res_type             res_chain [TABLE_DEPTH+1];

   // unpack request word
   assign first_ip    = req_tdata[31:0];
   assign first_port  = req_tdata[47:32];
   assign second_ip   = req_tdata[79:48];
   assign second_port = req_tdata[95:80];
   assign owner_id    = req_tdata[127:96];
   assign conn_state  = req_tdata[135:128];
   assign op          = op_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign filtered = (conn_state[7:4] != 4'd0) || !state_mask_ff[conn_state[3:0]];
   assign full     = (count_ff >= CNT_W'(TABLE_DEPTH));

   assign wr_entry.owner     = owner_id;
   assign wr_entry.peer_port = second_port;
   assign wr_entry.peer_ip   = second_ip;
   assign wr_entry.own_port  = first_port;
   assign wr_entry.own_ip    = first_ip;

   // launch the lookup key into the first cell
   assign key_chain[0].use1  = (first_port >= lowest_port_ff);
   assign key_chain[0].use2  = (second_port >= lowest_port_ff);
   assign key_chain[0].ip1   = first_ip;
   assign key_chain[0].port1 = first_port;
   assign key_chain[0].ip2   = second_ip;
   assign key_chain[0].port2 = second_port;
   assign res_chain[0].tok   = req_accept && (op == OP_LOOKUP);
   assign res_chain[0].found = 1'b0;
   assign res_chain[0].owner = '0;

   // row of entry cells
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      col_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(g)),
         .ctl      (ctl),
         .wr_entry (wr_entry),
         .key_in   (key_chain[g]),
         .res_in   (res_chain[g]),
         .key_out  (key_chain[g+1]),
         .res_out  (res_chain[g+1])
      );
   end

   // sequence operations and build the response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      ctl.wr_en    = 1'b0;
      ctl.wr_idx   = count_ff[IDX_W-1:0];
      ctl.count    = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_in.owner  = '0;
               rsp_in.found  = 1'b0;
               rsp_in.status = STATUS_OK;
               rsp_in.count  = COUNT_W'(count_ff);
               case (op)
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_in.count = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (filtered) begin
                        rsp_in.status = STATUS_FILTERED;
                     end else if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        ctl.wr_en    = 1'b1;
                        count_in     = count_ff + CNT_W'(1);
                        rsp_in.count = COUNT_W'(count_in);
                     end
                  end
                  OP_LOOKUP: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (res_chain[TABLE_DEPTH].tok) begin
               pend_in  = res_chain[TABLE_DEPTH];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_in.owner  = pend_ff.owner;
               rsp_in.found  = pend_ff.found;
               rsp_in.status = STATUS_OK;
               rsp_in.count  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         lowest_port_ff <= LOWEST_PORT_RESET;
         state_mask_ff  <= STATE_MASK_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_addr == REG_LOWEST_PORT) begin
            lowest_port_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == REG_STATE_MASK) begin
            state_mask_ff <= csr_wdata;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_ff);

   // fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   // a lookup moves the sequencer into the scan
   a_lookup_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept && op == OP_LOOKUP |=> state_ff == ST_SCAN)
      else $error("lookup accepted without scan");

   // a result leaves the chain only while scanning
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      res_chain[TABLE_DEPTH].tok |-> state_ff == ST_SCAN)
      else $error("chain result outside scan");

   // no request is taken while a lookup is in flight
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("request ready while busy");

endmodule

// ----- hw/rtl/col_cell.sv -----
module col_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [col_pkg::IDX_W-1:0] cell_idx,
   input  col_pkg::ctl_type      ctl,
   input  col_pkg::entry_type    wr_entry,
   input  col_pkg::key_type      key_in,
   input  col_pkg::res_type      res_in,
   output col_pkg::key_type      key_out,
   output col_pkg::res_type      res_out
);
   import col_pkg::*;

   entry_type entry_ff, entry_in;
   key_type   key_ff, key_in_next;
   res_type   res_ff, res_in_next;
   logic      valid;
   logic      hit1;
   logic      hit2;
   logic      hit;

   // entry is live when it sits below the fill count
   assign valid = (CNT_W'(cell_idx) < ctl.count);

   // a used packet endpoint already passes the threshold, so an equal
   // entry endpoint passes it as well
   assign hit1 = key_in.use1 &&
                 ((entry_ff.own_ip == key_in.ip1 && entry_ff.own_port == key_in.port1) ||
                  (entry_ff.peer_ip == key_in.ip1 && entry_ff.peer_port == key_in.port1));
   assign hit2 = key_in.use2 &&
                 ((entry_ff.own_ip == key_in.ip2 && entry_ff.own_port == key_in.port2) ||
                  (entry_ff.peer_ip == key_in.ip2 && entry_ff.peer_port == key_in.port2));
   assign hit  = valid && (hit1 || hit2);

   // store on insert, pass key along, keep the first hit
   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr_en && ctl.wr_idx == cell_idx) begin
         entry_in = wr_entry;
      end
      key_in_next       = key_in;
      res_in_next.tok   = res_in.tok;
      res_in_next.found = res_in.found || hit;
      if (res_in.found) begin
         res_in_next.owner = res_in.owner;
      end else if (hit) begin
         res_in_next.owner = entry_ff.owner;
      end else begin
         res_in_next.owner = '0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      key_ff       <= key_in_next;
      res_ff.found <= res_in_next.found;
      res_ff.owner <= res_in_next.owner;
      if (reset) begin
         res_ff.tok <= 1'b0;
      end else begin
         res_ff.tok <= res_in_next.tok;
      end
   end

   assign key_out = key_ff;
   assign res_out = res_ff;

endmodule

// ----- tb/tb_connection_owner_lookup_top.sv -----
module tb_connection_owner_lookup_top;
   timeunit 1ns;
   timeprecision 1ps;

   import col_pkg::*;

   localparam int ITEMS_PER_SEG = 277;
   localparam int LONG_HOLD     = 400;
   localparam int LOOKUP_CYCLES = TABLE_DEPTH + 2;
   localparam int ANSWER_W      = $bits(rsp_type);

   // one request word, split into its fields
   typedef struct {
      op_type              op;
      logic [IP_W-1:0]     first_ip;
      logic [PORT_W-1:0]   first_port;
      logic [IP_W-1:0]     second_ip;
      logic [PORT_W-1:0]   second_port;
      logic [OWNER_W-1:0]  owner_id;
      logic [CSTATE_W-1:0] conn_state;
   } conn_req_type;

   typedef enum logic [1:0] {
      ROW_WORD,
      ROW_CSR,
      ROW_FILL
   } row_kind_type;

   // one line of the directed stimulus table
   typedef struct {
      row_kind_type     kind;
      conn_req_type     item;
      bit               has_answer;
      rsp_type          answer;
      logic             csr_sel;
      logic [CSR_W-1:0] csr_val;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [1:0]         req_tuser = OP_CLEAR;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_we = 1'b0;
   logic               csr_addr = REG_LOWEST_PORT;
   logic [CSR_W-1:0]   csr_wdata = '0;

   // shadow of the table and its registers
   entry_type          held_entries [TABLE_DEPTH];
   int                 held_count = 0;
   logic [PORT_W-1:0]  lowest_port_cfg = LOWEST_PORT_RESET;
   logic [CSR_W-1:0]   state_mask_cfg = STATE_MASK_RESET;

   rsp_type            pending_answers [$];
   int                 error_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 hold_asked = 0;

   logic [IP_W-1:0]    ip_pool [8];
   logic [PORT_W-1:0]  port_pool [8];

   connection_owner_lookup_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // stop a hung run
   initial begin
      #(4_000_000);
      $display("TB_ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got_v,
                                input logic [63:0] want_v);
      if (error_count < 100)
         $display("mismatch: %s got %0h want %0h at %0t", what, got_v, want_v, $realtime);
      error_count++;
   endtask

   // an entry side takes part only when its port is tracked
   function automatic bit endpoint_hits(input entry_type e, input logic [IP_W-1:0] ip,
                                        input logic [PORT_W-1:0] port);
      if (e.own_port >= lowest_port_cfg && e.own_ip == ip && e.own_port == port)
         return 1'b1;
      if (e.peer_port >= lowest_port_cfg && e.peer_ip == ip && e.peer_port == port)
         return 1'b1;
      return 1'b0;
   endfunction

   // apply one request to the shadow table and return its answer
   function automatic rsp_type table_outcome(input conn_req_type it);
      rsp_type r;
      bit      use1;
      bit      use2;
      r = '0;
      use1 = it.first_port >= lowest_port_cfg;
      use2 = it.second_port >= lowest_port_cfg;
      case (it.op)
         OP_CLEAR: begin
            held_count = 0;
         end
         OP_INSERT: begin
            if (it.conn_state > 8'd15 || !state_mask_cfg[it.conn_state[3:0]]) begin
               r.status = STATUS_FILTERED;
            end else if (held_count >= TABLE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               held_entries[held_count].own_ip    = it.first_ip;
               held_entries[held_count].own_port  = it.first_port;
               held_entries[held_count].peer_ip   = it.second_ip;
               held_entries[held_count].peer_port = it.second_port;
               held_entries[held_count].owner     = it.owner_id;
               held_count++;
            end
         end
         OP_LOOKUP: begin
            // first hit in insertion order wins
            for (int i = 0; i < held_count; i++) begin
               if (!r.found &&
                   ((use1 && endpoint_hits(held_entries[i], it.first_ip, it.first_port)) ||
                    (use2 && endpoint_hits(held_entries[i], it.second_ip, it.second_port))))
               begin
                  r.owner = held_entries[i].owner;
                  r.found = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      r.count = 7'(held_count);
      return r;
   endfunction

   function automatic row_type request_row(input op_type op, input logic [IP_W-1:0] ip1,
                                           input logic [PORT_W-1:0] p1,
                                           input logic [IP_W-1:0] ip2,
                                           input logic [PORT_W-1:0] p2,
                                           input logic [OWNER_W-1:0] own,
                                           input logic [CSTATE_W-1:0] st);
      row_type r;
      r.kind = ROW_WORD;
      r.item.op = op;
      r.item.first_ip = ip1;
      r.item.first_port = p1;
      r.item.second_ip = ip2;
      r.item.second_port = p2;
      r.item.owner_id = own;
      r.item.conn_state = st;
      r.has_answer = 1'b0;
      r.answer = '0;
      r.csr_sel = REG_LOWEST_PORT;
      r.csr_val = '0;
      return r;
   endfunction

   function automatic row_type with_answer(input row_type r, input logic [OWNER_W-1:0] own,
                                           input logic fnd, input status_type st,
                                           input int cnt);
      r.has_answer = 1'b1;
      r.answer.owner = own;
      r.answer.found = fnd;
      r.answer.status = st;
      r.answer.count = 7'(cnt);
      return r;
   endfunction

   function automatic row_type register_row(input logic sel, input logic [CSR_W-1:0] val);
      row_type r;
      r = request_row(OP_NOP, '0, '0, '0, '0, '0, '0);
      r.kind = ROW_CSR;
      r.csr_sel = sel;
      r.csr_val = val;
      return r;
   endfunction

   function automatic logic [IP_W-1:0] pick_ip();
      if ($urandom_range(0, 9) < 7)
         return ip_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [PORT_W-1:0] pick_port();
      if ($urandom_range(0, 9) < 7)
         return port_pool[$urandom_range(0, 7)];
      return 16'($urandom);
   endfunction

   // offer one word, wait for the handshake, then queue its answer
   task automatic send_word(input conn_req_type it, input bit fixed,
                            input rsp_type fixed_answer);
      rsp_type answer;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {it.conn_state, it.owner_id, it.second_port, it.second_ip,
                     it.first_port, it.first_ip};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answer = table_outcome(it);
      pending_answers.push_back(fixed ? fixed_answer : answer);
   endtask

   // hold the request side until every answer is back
   task automatic drain_answers();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic sel, input logic [CSR_W-1:0] val);
      drain_answers();
      csr_we    <= 1'b1;
      csr_addr  <= sel;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == REG_LOWEST_PORT)
         lowest_port_cfg = val;
      else
         state_mask_cfg = val;
      @(posedge clock);
   endtask

   // response side: random stalls plus one long hold on request
   initial begin : receiver
      int hold_left;
      int hold_granted;
      hold_left = 0;
      hold_granted = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_asked != hold_granted) begin
            hold_granted = hold_asked;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // compare each answer word with the oldest pending one
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[ANSWER_W-1:0];
         if (pending_answers.size() == 0) begin
            flag_mismatch("answer with nothing pending", 64'(rsp_tdata), 64'd0);
         end else begin
            want = pending_answers.pop_front();
            if (got.owner !== want.owner)
               flag_mismatch("owner_out", 64'(got.owner), 64'(want.owner));
            if (got.found !== want.found)
               flag_mismatch("found", 64'(got.found), 64'(want.found));
            if (got.status !== want.status)
               flag_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.count !== want.count)
               flag_mismatch("entry_count_out", 64'(got.count), 64'(want.count));
            if (rsp_tdata[RSP_W-1:ANSWER_W] !== '0)
               flag_mismatch("pad", 64'(rsp_tdata[RSP_W-1:ANSWER_W]), 64'd0);
         end
      end
   end

   initial begin : stimulus
      row_type           rows [$];
      row_type           r;
      conn_req_type      it;
      entry_type         e;
      int                roll;
      int                clear_rate;
      int                thr;
      int                near;
      logic [CSR_W-1:0]  mask;

      // directed table, default registers first
      rows.push_back(with_answer(request_row(OP_LOOKUP, 32'hC0A8_0001, 16'd5000,
                     32'h0A00_0001, 16'd2000, '0, 8'd0), '0, 1'b0, STATUS_OK, 0));
      rows.push_back(with_answer(request_row(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF,
                     32'h0, 16'd1024, 32'hFFFF_FFFF, 8'd1), '0, 1'b0, STATUS_OK, 1));
      rows.push_back(with_answer(request_row(OP_INSERT, 32'h0102_0304, 16'd3000,
                     32'h0506_0708, 16'd3001, 32'h55, 8'd0), '0, 1'b0, STATUS_FILTERED, 1));
      rows.push_back(with_answer(request_row(OP_INSERT, 32'h0102_0304, 16'd3000,
                     32'h0506_0708, 16'd3001, 32'h56, 8'hFF), '0, 1'b0, STATUS_FILTERED, 1));
      rows.push_back(with_answer(request_row(OP_INSERT, 32'h0102_0304, 16'd3000,
                     32'h0506_0708, 16'd3001, 32'h57, 8'd16), '0, 1'b0, STATUS_FILTERED, 1));
      rows.push_back(with_answer(request_row(OP_INSERT, 32'h0A00_0001, 16'd2000,
                     32'h0A00_0002, 16'd80, '0, 8'd10), '0, 1'b0, STATUS_OK, 2));
      rows.push_back(with_answer(request_row(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF,
                     32'h0, 16'd0, '0, 8'd0), 32'hFFFF_FFFF, 1'b1, STATUS_OK, 2));
      rows.push_back(request_row(OP_LOOKUP, 32'h0A00_0002, 16'd80,
                     32'h0102_0304, 16'd5000, '0, 8'd0));
      // owner id zero still reports a hit
      rows.push_back(with_answer(request_row(OP_LOOKUP, 32'h0909_0909, 16'd9,
                     32'h0A00_0001, 16'd2000, '0, 8'd0), '0, 1'b1, STATUS_OK, 2));
      rows.push_back(with_answer(request_row(OP_NOP, '1, '1, '1, '1, '1, '1),
                     '0, 1'b0, STATUS_OK, 2));
      // threshold zero lets low ports match
      rows.push_back(register_row(REG_LOWEST_PORT, 16'd0));
      rows.push_back(request_row(OP_LOOKUP, 32'h0A00_0002, 16'd80, 32'h1, 16'd1, '0, 8'd0));
      rows.push_back(request_row(OP_LOOKUP, 32'h0, 16'd0, 32'h0, 16'd1024, '0, 8'd0));
      rows.push_back(register_row(REG_LOWEST_PORT, 16'hFFFF));
      rows.push_back(request_row(OP_LOOKUP, 32'h1, 16'd1, 32'hFFFF_FFFF, 16'hFFFF, '0, 8'd0));
      rows.push_back(request_row(OP_LOOKUP, 32'h0, 16'd1024, 32'h0, 16'd0, '0, 8'd0));
      rows.push_back(with_answer(request_row(OP_CLEAR, '1, '1, '1, '1, '1, '1),
                     '0, 1'b0, STATUS_OK, 0));
      // fill the table, then probe full and filter order
      rows.push_back(register_row(REG_LOWEST_PORT, 16'd1024));
      rows.push_back(register_row(REG_STATE_MASK, 16'hFFFF));
      r = request_row(OP_INSERT, 32'h0A01_0000, 16'd3000, 32'hC0A8_0000, 16'd4000,
                      '0, 8'd1);
      r.kind = ROW_FILL;
      rows.push_back(r);
      rows.push_back(with_answer(request_row(OP_INSERT, 32'h7, 16'd7000, 32'h8, 16'd8000,
                     32'h99, 8'd3), '0, 1'b0, STATUS_FULL, TABLE_DEPTH));
      rows.push_back(with_answer(request_row(OP_INSERT, 32'h7, 16'd7000, 32'h8, 16'd8000,
                     32'h99, 8'd20), '0, 1'b0, STATUS_FILTERED, TABLE_DEPTH));
      rows.push_back(request_row(OP_LOOKUP, 32'h3, 16'd3, 32'hC0A8_0000, 16'd4000,
                     '0, 8'd0));
      rows.push_back(request_row(OP_LOOKUP, 32'h0A01_003F, 16'd3063, 32'h3, 16'd3,
                     '0, 8'd0));
      rows.push_back(register_row(REG_STATE_MASK, 16'h0000));
      rows.push_back(with_answer(request_row(OP_CLEAR, '0, '0, '0, '0, '0, '0),
                     '0, 1'b0, STATUS_OK, 0));
      rows.push_back(with_answer(request_row(OP_INSERT, 32'h7, 16'd7000, 32'h8, 16'd8000,
                     32'h99, 8'd5), '0, 1'b0, STATUS_FILTERED, 0));
      rows.push_back(request_row(OP_LOOKUP, '0, '0, '0, '0, '0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      send_idle_pct = 28;
      recv_idle_pct = 86;
      foreach (rows[n]) begin
         case (rows[n].kind)
            ROW_CSR: begin
               write_csr(rows[n].csr_sel, rows[n].csr_val);
            end
            ROW_FILL: begin
               for (int k = 0; k < TABLE_DEPTH; k++) begin
                  it = rows[n].item;
                  it.first_ip = it.first_ip + k;
                  it.first_port = it.first_port + 16'(k);
                  it.owner_id = 32'h0100_0000 + k;
                  send_word(it, 1'b0, '0);
               end
            end
            default: begin
               send_word(rows[n].item, rows[n].has_answer, rows[n].answer);
            end
         endcase
      end

      // random segments, each with its own register setting
      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0: begin thr = 0;                       mask = 16'hFFFF;  clear_rate = 15; end
            1: begin thr = 65535;                   mask = 16'hFFFF;  clear_rate = 15; end
            2: begin thr = $urandom_range(1, 4096); mask = 16'($urandom); clear_rate = 3; end
            3: begin thr = 1024;                    mask = 16'd1150;  clear_rate = 15; end
            4: begin thr = $urandom_range(0, 65535); mask = 16'($urandom); clear_rate = 3; end
            default: begin thr = 1024;              mask = 16'hFFFF;  clear_rate = 15; end
         endcase
         write_csr(REG_LOWEST_PORT, 16'(thr));
         write_csr(REG_STATE_MASK, mask);
         send_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 86 : 0;
         recv_idle_pct = (seg < 2) ? 86 : (seg < 4) ? 28 : 0;
         // stall the answers long enough to back up the requests
         if (seg == 4)
            hold_asked++;

         // endpoints clustered around the threshold so hits are common
         ip_pool[0] = '0;
         ip_pool[1] = '1;
         for (int k = 2; k < 8; k++)
            ip_pool[k] = $urandom;
         for (int k = 0; k < 3; k++) begin
            near = thr + k - 1;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            port_pool[k] = 16'(near);
         end
         port_pool[3] = 16'd0;
         port_pool[4] = 16'hFFFF;
         for (int k = 5; k < 8; k++)
            port_pool[k] = 16'($urandom);

         repeat (ITEMS_PER_SEG) begin
            roll = $urandom_range(0, 999);
            if (roll < clear_rate)
               it.op = OP_CLEAR;
            else if (roll < clear_rate + 35)
               it.op = OP_NOP;
            else if (roll < 480)
               it.op = OP_INSERT;
            else
               it.op = OP_LOOKUP;
            it.first_ip = pick_ip();
            it.first_port = pick_port();
            it.second_ip = pick_ip();
            it.second_port = pick_port();
            case ($urandom_range(0, 19))
               0:       it.owner_id = '0;
               1:       it.owner_id = '1;
               default: it.owner_id = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0)
               it.conn_state = 8'($urandom_range(16, 255));
            else
               it.conn_state = 8'($urandom_range(0, 15));
            // aim most lookups at a stored endpoint, some just off it
            if (it.op == OP_LOOKUP && held_count > 0 && $urandom_range(0, 9) < 6) begin
               e = held_entries[$urandom_range(0, held_count - 1)];
               case ($urandom_range(0, 3))
                  0: begin it.first_ip = e.own_ip;    it.first_port = e.own_port;    end
                  1: begin it.first_ip = e.peer_ip;   it.first_port = e.peer_port;   end
                  2: begin it.second_ip = e.own_ip;   it.second_port = e.own_port;   end
                  default: begin
                     it.second_ip = e.peer_ip;
                     it.second_port = e.peer_port;
                  end
               endcase
               if ($urandom_range(0, 7) == 0)
                  it.first_port = it.first_port ^ 16'h0001;
            end
            send_word(it, 1'b0, '0);
         end
      end

      // let the last answers drain, then give a stray word time to show
      drain_answers();
      repeat (LOOKUP_CYCLES + 8) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
